// File: design/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg: shared constants for the first-fit heap allocator
// Request codes and default geometry.
// ----------------------------------------------------------------------------
`default_nettype none
package ffha_pkg;
  localparam int unsigned DefHeapBytes  = 4096;
  localparam int unsigned DefAlignBytes = 4;
  localparam int unsigned DefMinData    = 16;
  localparam int unsigned DefHdrBytes   = 8;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_TRIM  = 2'd2;
endpackage
`default_nettype wire

// File: design/first_fit_heap_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top: first-fit heap allocator with coalescing
// An allocate refused up front goes straight to the response beat; otherwise it
// visits blocks one by one, may split the block it takes and may check headers
// while moving the lowest free block. One request is in flight at a time; the
// next beat is taken the cycle after the response beat. The header memory has
// one read port with a registered output and one write port. After reset a
// clearing pass writes every header entry before the first beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module first_fit_heap_allocator_top
  import ffha_pkg::*;
#(
  parameter int unsigned HEAP_BYTES     = DefHeapBytes,
  parameter int unsigned ALIGN_BYTES    = DefAlignBytes,
  parameter int unsigned MIN_DATA_BYTES = DefMinData,
  parameter int unsigned HEADER_BYTES   = DefHdrBytes
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [39:0] in_tdata,   // op[1:0], req_size[17:2], data_offset[33:18], zero
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata   // result_offset[15:0], status[16], zero
);
  localparam int unsigned HeapA  = ((HEAP_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam int unsigned HdrA   = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam int unsigned MinA   = ((MIN_DATA_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam int unsigned Depth  = HeapA / ALIGN_BYTES + 1;
  localparam int unsigned AW     = $clog2(Depth);
  localparam int unsigned OW     = 18;   // offsets and sums up to ~2^17 fit
  localparam int unsigned ALG    = $clog2(ALIGN_BYTES) > 0 ? $clog2(ALIGN_BYTES) : 1;
  localparam int unsigned EW     = 2 * OW + 1;

  localparam logic [OW-1:0] HEAP_O = OW'(HeapA);
  localparam logic [OW-1:0] HDR_O  = OW'(HdrA);
  localparam logic [OW-1:0] MIN_O  = OW'(MinA);
  localparam logic [OW-1:0] ALM_O  = OW'(ALIGN_BYTES - 1);

  // header entry {used, prev, next}
  typedef struct packed {
    logic          used;
    logic [OW-1:0] prev;
    logic [OW-1:0] nxt;
  } hdr_t;

  localparam logic [5:0]
    S_CLR = 6'd0,  S_IDLE = 6'd1,  S_OUT = 6'd2,
    A_RD = 6'd3,   A_WT = 6'd4,    A_CHK = 6'd5,
    A_SPL = 6'd6,  A_NRD = 6'd7,   A_NWT = 6'd8,  A_NWR = 6'd9,
    L_RD = 6'd10,  L_WT = 6'd11,   L_CHK = 6'd12,
    F_RD = 6'd13,  F_WT = 6'd14,   F_CHK = 6'd15,
    M_NRD = 6'd16, M_NWT = 6'd17,  M_NCK = 6'd18,
    M_NNRD = 6'd19, M_NNWT = 6'd20, M_NNWR = 6'd21,
    M_PRD = 6'd22, M_PWT = 6'd23,  M_PCK = 6'd24,
    M_QRD = 6'd25, M_QWT = 6'd26,  M_QWR = 6'd27,
    T_RD = 6'd28,  T_WT = 6'd29,   T_CHK = 6'd30,
    T_NRD = 6'd31, T_NWT = 6'd32,  T_NCK = 6'd33,
    T_WR2 = 6'd34, T_NNRD = 6'd35, T_NNWT = 6'd36, T_NNWR = 6'd37;

  // header memory
  hdr_t mem [Depth];
  logic          we;
  logic [AW-1:0] wa, ra;
  hdr_t          wd, rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[ra];
  end

  logic [5:0]    st_r, st_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [OW-1:0] s_r, s_nxt, d_r, d_nxt;
  logic [OW-1:0] ptr_r, ptr_nxt, nxt_r, nxt_nxt, aux_r, aux_nxt, lf_r, lf_nxt;
  logic [OW-1:0] cnt_r, cnt_nxt;
  hdr_t          h_r, h_nxt;
  logic [15:0]   res_r, res_nxt;
  logic          sts_r, sts_nxt;

  // offset to memory index; reads of out-of-range offsets return zero
  function automatic logic [AW-1:0] idx(input logic [OW-1:0] o);
    logic [OW-1:0] q;
    q = o >> ALG;
    if (ALIGN_BYTES == 1) q = o;
    return AW'(q);
  endfunction
  function automatic logic inr(input logic [OW-1:0] o);
    return (o >> (ALIGN_BYTES == 1 ? 0 : ALG)) < OW'(Depth);
  endfunction

  logic [OW-1:0] req_w, dof_w, sz_w, s_al;
  hdr_t          rdv;
  logic          rd_in_r;
  logic [OW-1:0] ptr_nxt_q;

  always_ff @(posedge clk) rd_in_r <= inr(ptr_nxt_q);
  assign rdv = rd_in_r ? rd_r : '0;

  assign req_w = OW'(in_tdata[17:2]);
  assign dof_w = OW'(in_tdata[33:18]);
  assign sz_w  = ((req_w + ALM_O) >> (ALIGN_BYTES == 1 ? 0 : ALG)) << (ALIGN_BYTES == 1 ? 0 : ALG);
  assign s_al  = (ALIGN_BYTES == 1) ? req_w : sz_w;

  function automatic logic aligned(input logic [OW-1:0] o);
    return (o & ALM_O) == '0;
  endfunction

  always_comb begin
    st_nxt = st_r; clr_nxt = clr_r; op_nxt = op_r; s_nxt = s_r; d_nxt = d_r;
    ptr_nxt = ptr_r; nxt_nxt = nxt_r; aux_nxt = aux_r; lf_nxt = lf_r;
    cnt_nxt = cnt_r; h_nxt = h_r; res_nxt = res_r; sts_nxt = sts_r;
    we = 1'b0; wa = '0; wd = '0;
    ptr_nxt_q = ptr_r;   // address driving the read
    in_tready = 1'b0;
    case (st_r)
      S_CLR: begin
        we = 1'b1; wa = clr_r;
        if (clr_r == '0) wd = '{used: 1'b0, prev: '0, nxt: HEAP_O};
        else if (clr_r == idx(HEAP_O)) wd = '{used: 1'b1, prev: HEAP_O, nxt: HEAP_O};
        if (clr_r == AW'(Depth - 1)) st_nxt = S_IDLE;
        clr_nxt = clr_r + 1'b1;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt = in_tdata[1:0];
          d_nxt = dof_w;
          s_nxt = (s_al < MIN_O) ? MIN_O : s_al;
          res_nxt = '0; sts_nxt = 1'b1; cnt_nxt = '0;
          case (in_tdata[1:0])
            OP_ALLOC: begin
              if (req_w == '0 || ((s_al < MIN_O) ? MIN_O : s_al) > HEAP_O) st_nxt = S_OUT;
              else begin ptr_nxt = lf_r; st_nxt = A_RD; end
            end
            OP_FREE: begin
              sts_nxt = 1'b0;
              if (dof_w < HDR_O || dof_w >= HEAP_O || !aligned(dof_w - HDR_O)) st_nxt = S_OUT;
              else begin ptr_nxt = dof_w - HDR_O; st_nxt = F_RD; end
            end
            OP_TRIM: begin
              if (((s_al < MIN_O) ? MIN_O : s_al) > HEAP_O) st_nxt = S_OUT;
              else begin
                res_nxt = in_tdata[33:18]; sts_nxt = (in_tdata[33:18] == '0);
                if (dof_w < HDR_O || dof_w >= HEAP_O || !aligned(dof_w - HDR_O)) st_nxt = S_OUT;
                else begin ptr_nxt = dof_w - HDR_O; st_nxt = T_RD; end
              end
            end
            default: st_nxt = S_OUT;
          endcase
        end
      end
      S_OUT: if (out_tready) st_nxt = S_IDLE;
      // ---- allocate scan
      A_RD: begin
        if (cnt_r >= OW'(Depth) || !(ptr_r < HEAP_O - s_r)) st_nxt = S_OUT;
        else st_nxt = A_WT;
      end
      A_WT: st_nxt = A_CHK;
      A_CHK: begin
        h_nxt = rdv; nxt_nxt = rdv.nxt;
        if (!rdv.used && rdv.nxt >= ptr_r + HDR_O && rdv.nxt - ptr_r - HDR_O >= s_r) begin
          res_nxt = 16'(ptr_r + HDR_O); sts_nxt = 1'b0;
          if (rdv.nxt - ptr_r - HDR_O >= s_r + HDR_O + MIN_O) begin
            aux_nxt = ptr_r + HDR_O + s_r; st_nxt = A_SPL;
          end else begin
            we = inr(ptr_r); wa = idx(ptr_r); wd = rdv; wd.used = 1'b1;
            st_nxt = (ptr_r == lf_r) ? L_RD : S_OUT;
            cnt_nxt = '0;
          end
        end else begin
          ptr_nxt = rdv.nxt; cnt_nxt = cnt_r + 1'b1; st_nxt = A_RD;
        end
      end
      A_SPL: begin
        we = inr(aux_r); wa = idx(aux_r);
        wd = '{used: 1'b0, prev: ptr_r, nxt: nxt_r};
        st_nxt = A_NRD;
      end
      A_NRD: begin
        we = inr(ptr_r); wa = idx(ptr_r); wd = h_r; wd.used = 1'b1; wd.nxt = aux_r;
        ptr_nxt_q = nxt_r;
        st_nxt = (nxt_r != HEAP_O) ? A_NWT : ((ptr_r == lf_r) ? L_RD : S_OUT);
        cnt_nxt = '0;
      end
      A_NWT: begin ptr_nxt_q = nxt_r; st_nxt = A_NWR; end
      A_NWR: begin
        we = inr(nxt_r); wa = idx(nxt_r); wd = rdv; wd.prev = aux_r;
        st_nxt = (ptr_r == lf_r) ? L_RD : S_OUT;
      end
      // ---- lowest-free walk
      L_RD: begin ptr_nxt_q = lf_r; st_nxt = L_WT; end
      L_WT: begin ptr_nxt_q = lf_r; st_nxt = L_CHK; end
      L_CHK: begin
        if (cnt_r >= OW'(Depth) || !rdv.used || lf_r == HEAP_O) st_nxt = S_OUT;
        else begin lf_nxt = rdv.nxt; cnt_nxt = cnt_r + 1'b1; st_nxt = L_RD; end
      end
      // ---- free
      F_RD: st_nxt = F_WT;
      F_WT: st_nxt = F_CHK;
      F_CHK: begin
        h_nxt = rdv;
        if (!rdv.used) st_nxt = S_OUT;
        else begin
          h_nxt.used = 1'b0;
          we = 1'b1; wa = idx(ptr_r); wd = rdv; wd.used = 1'b0;
          if (ptr_r < lf_r) lf_nxt = ptr_r;
          nxt_nxt = rdv.nxt; st_nxt = M_NRD;
        end
      end
      M_NRD: begin ptr_nxt_q = nxt_r; st_nxt = M_NWT; end
      M_NWT: begin ptr_nxt_q = nxt_r; st_nxt = M_NCK; end
      M_NCK: begin
        if (nxt_r != ptr_r && !rdv.used && nxt_r != HEAP_O) begin
          if (lf_r == nxt_r) lf_nxt = ptr_r;
          aux_nxt = rdv.nxt;
          h_nxt.nxt = rdv.nxt;
          we = 1'b1; wa = idx(ptr_r); wd = h_r; wd.nxt = rdv.nxt;
          st_nxt = M_NNRD;
        end else st_nxt = M_PRD;
      end
      M_NNRD: begin
        we = inr(nxt_r); wa = idx(nxt_r); wd = '0;
        ptr_nxt_q = aux_r; st_nxt = M_NNWT;
      end
      M_NNWT: begin ptr_nxt_q = aux_r; st_nxt = M_NNWR; end
      M_NNWR: begin
        we = inr(aux_r); wa = idx(aux_r); wd = rdv; wd.prev = ptr_r;
        st_nxt = M_PRD;
      end
      M_PRD: begin ptr_nxt_q = h_r.prev; st_nxt = M_PWT; end
      M_PWT: begin ptr_nxt_q = h_r.prev; st_nxt = M_PCK; end
      M_PCK: begin
        if (h_r.prev != ptr_r && !rdv.used) begin
          if (lf_r == ptr_r) lf_nxt = h_r.prev;
          we = inr(h_r.prev); wa = idx(h_r.prev); wd = rdv; wd.nxt = h_r.nxt;
          st_nxt = M_QRD;
        end else st_nxt = S_OUT;
      end
      M_QRD: begin
        ptr_nxt_q = h_r.nxt; st_nxt = M_QWT;
      end
      M_QWT: begin ptr_nxt_q = h_r.nxt; st_nxt = M_QWR; end
      M_QWR: begin
        // write prev of next first, then clear self (same slot when next == self)
        we = inr(h_r.nxt); wa = idx(h_r.nxt); wd = rdv; wd.prev = h_r.prev;
        st_nxt = T_WR2; aux_nxt = '1;
      end
      // ---- trim
      T_RD: st_nxt = T_WT;
      T_WT: st_nxt = T_CHK;
      T_CHK: begin
        h_nxt = rdv; nxt_nxt = rdv.nxt;
        aux_nxt = ptr_r + HDR_O + s_r;
        if (!rdv.used || rdv.nxt < ptr_r + HDR_O) st_nxt = S_OUT;
        else if (s_r > rdv.nxt - ptr_r - HDR_O) begin
          res_nxt = '0; sts_nxt = 1'b1; st_nxt = S_OUT;
        end else if (s_r == rdv.nxt - ptr_r - HDR_O) st_nxt = S_OUT;
        else st_nxt = T_NRD;
      end
      T_NRD: begin ptr_nxt_q = nxt_r; st_nxt = T_NWT; end
      T_NWT: begin ptr_nxt_q = nxt_r; st_nxt = T_NCK; end
      T_NCK: begin
        if (!rdv.used) begin
          we = inr(nxt_r); wa = idx(nxt_r); wd = '0;
          if (lf_r == nxt_r) lf_nxt = aux_r;
          cnt_nxt = rdv.nxt;   // reuse as nn
          st_nxt = T_WR2;
        end else if (s_r + HDR_O + MIN_O <= nxt_r - ptr_r - HDR_O) begin
          if (aux_r < lf_r) lf_nxt = aux_r;
          cnt_nxt = nxt_r;
          st_nxt = T_WR2;
        end else st_nxt = S_OUT;
      end
      T_WR2: begin
        if (op_r == OP_FREE) begin
          // clear the absorbed header of a merge with the previous block
          we = inr(ptr_r); wa = idx(ptr_r); wd = '0; st_nxt = S_OUT;
        end else begin
          we = inr(aux_r); wa = idx(aux_r);
          wd = '{used: 1'b0, prev: ptr_r, nxt: cnt_r};
          st_nxt = T_NNRD;
        end
      end
      T_NNRD: begin
        we = 1'b1; wa = idx(ptr_r); wd = h_r; wd.nxt = aux_r;
        ptr_nxt_q = cnt_r;
        st_nxt = (cnt_r != HEAP_O) ? T_NNWT : S_OUT;
      end
      T_NNWT: begin ptr_nxt_q = cnt_r; st_nxt = T_NNWR; end
      T_NNWR: begin
        we = inr(cnt_r); wa = idx(cnt_r); wd = rdv; wd.prev = aux_r;
        st_nxt = S_OUT;
      end
      default: st_nxt = S_IDLE;
    endcase
    if (st_r == S_IDLE || st_r == A_CHK) ptr_nxt_q = ptr_nxt;
    ra = idx(ptr_nxt_q);
  end

  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata  = {7'd0, sts_r, res_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; lf_r <= '0;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt; lf_r <= lf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; s_r <= s_nxt; d_r <= d_nxt; ptr_r <= ptr_nxt; nxt_r <= nxt_nxt;
    aux_r <= aux_nxt; cnt_r <= cnt_nxt; h_r <= h_nxt; res_r <= res_nxt; sts_r <= sts_nxt;
  end

  logic unused_ok;
  assign unused_ok = ^{d_r, in_tdata[39:34], EW'(0)};
endmodule
`default_nettype wire
